// ----- design/rau_pkg.sv -----
//------------------------------------------------------------------------------
// rau_pkg
// Shared types and constants for the rational arithmetic unit.
//------------------------------------------------------------------------------
`default_nettype none
package rau_pkg;
   localparam int DefWidth = 32;

   typedef enum logic [2:0] {
      MODE_ADD = 3'd0,
      MODE_SUB = 3'd1,
      MODE_MUL = 3'd2,
      MODE_DIV = 3'd3,
      MODE_CMP = 3'd4
   } mode_type;

   typedef enum logic [1:0] {
      ST_OK       = 2'd0,
      ST_ZERO_DEN = 2'd1,
      ST_DIV_ZERO = 2'd2,
      ST_OVERFLOW = 2'd3
   } status_type;

   // request to the shared divider
   typedef struct packed {
      logic start;
   } div_ctl_type;
endpackage
`default_nettype wire

// ----- design/rau_div.sv -----
//------------------------------------------------------------------------------
// rau_div
// Restoring bit-serial unsigned divider, one quotient bit per cycle.
//------------------------------------------------------------------------------
`default_nettype none
module rau_div import rau_pkg::*; #(
   parameter int W = 64
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire div_ctl_type  ctl,
   input  wire logic [W-1:0] dividend,
   input  wire logic [W-1:0] divisor,
   output logic              done,
   output logic [W-1:0]      quot,
   output logic [W-1:0]      rem
);
   localparam int CW = $clog2(W + 1);
   logic [W-1:0] q_ff, r_ff, d_ff;
   logic [CW-1:0] cnt_ff;
   logic busy_ff;
   logic [W:0] sh, diff;

   assign sh   = {r_ff, q_ff[W-1]};
   assign diff = sh - {1'b0, d_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done    <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done <= 1'b0;
         if (ctl.start) begin
            busy_ff <= 1'b1;
            q_ff    <= dividend;
            r_ff    <= '0;
            d_ff    <= divisor;
            cnt_ff  <= CW'(W);
         end else if (busy_ff) begin
            if (!diff[W]) begin
               r_ff <= diff[W-1:0];
               q_ff <= {q_ff[W-2:0], 1'b1};
            end else begin
               r_ff <= sh[W-1:0];
               q_ff <= {q_ff[W-2:0], 1'b0};
            end
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == CW'(1)) begin
               busy_ff <= 1'b0;
               done    <= 1'b1;
            end
         end
      end
   end
   assign quot = q_ff;
   assign rem  = r_ff;
endmodule
`default_nettype wire

// ----- design/rational_arithmetic_unit.sv -----
// Item time depends on the data. Each Euclid remainder step and each exact divide is one
// run of the shared 64-bit bit-serial divider (start, iterations, result).
// A zero denominator answers the cycle after the transfer; for other items the time
// grows with the operand sizes and with the length of the Euclid chains.
// One item at a time; req_ready is low from acceptance until the result transfer.
// Synchronous reset returns to idle with no result pending.
//------------------------------------------------------------------------------
// rational_arithmetic_unit
// Fraction add/sub/mul/div/compare with GCD reduction, sequenced over one
// shared divider and one multiplier.
//------------------------------------------------------------------------------
`default_nettype none
module rational_arithmetic_unit import rau_pkg::*; #(
   parameter int WIDTH = DefWidth
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [2:0]  req_mode,
   input  wire logic signed [31:0] req_a_num,
   input  wire logic signed [31:0] req_a_den,
   input  wire logic signed [31:0] req_b_num,
   input  wire logic signed [31:0] req_b_den,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic signed [31:0] rsp_res_num,
   output logic [30:0]      rsp_res_den,
   output logic             rsp_is_equal,
   output logic [1:0]       rsp_status
);
   localparam int M = 64;   // magnitude width; products up to 2^62
   typedef logic [M-1:0] mag_type;

   typedef enum logic [4:0] {
      S_IDLE, S_G_START, S_G_WAIT, S_Q1_START, S_Q1_WAIT, S_Q2_START, S_Q2_WAIT,
      S_RED_DONE, S_OP, S_L1_START, S_L1_WAIT, S_L2, S_L3_START, S_L3_WAIT,
      S_L4_START, S_L4_WAIT, S_L5, S_MUL, S_CHECK, S_OUT
   } state_type;

   state_type state_ff;
   logic [1:0] phase_ff;  // 0: reduce a, 1: reduce b, 2: reduce result, 3: gcd of denominators
   logic [2:0] mode_ff;
   logic an_neg_ff, bn_neg_ff, n_neg_ff;
   mag_type an_ff, ad_ff, bn_ff, bd_ff, n_ff, d_ff, l_ff, s_ff, p1_ff;
   mag_type ga_ff, gb_ff, x_ff, y_ff;
   logic rn_neg_ff;
   logic eq_ff;
   logic [1:0] st_ff;

   div_ctl_type dctl;
   mag_type dvd, dvs, dq, dr;
   logic ddone;
   rau_div #(.W(M)) u_div (
      .clock(clock), .reset(reset), .ctl(dctl), .dividend(dvd), .divisor(dvs),
      .done(ddone), .quot(dq), .rem(dr)
   );

   // shared 32x32 magnitude multiplier, operands registered
   mag_type prod;
   assign prod = {32'd0, x_ff[31:0]} * {32'd0, y_ff[31:0]};

   mag_type top;
   assign top = mag_type'(1) << (WIDTH - 1);
   function automatic logic fit(input logic neg, input mag_type m, input mag_type t);
      fit = neg ? (m <= t) : (m <= t - 1);
   endfunction

   function automatic mag_type absf(input logic [31:0] v);
      absf = v[31] ? mag_type'(33'h1_0000_0000 - {1'b0, v}) : mag_type'(v);
   endfunction

   logic add_same;
   logic [M:0] sum_w;
   logic sum_neg, p2_neg;
   mag_type sum_m;
   // signs of the two cross products: mul gives n and a positive d,
   // div and compare give an*bd and (ad*bn or bn*ad)
   logic xp1_neg, xp2_neg;
   assign xp1_neg = (mode_ff == MODE_MUL) ? n_neg_ff : an_neg_ff;
   assign xp2_neg = (mode_ff == MODE_MUL) ? 1'b0 : bn_neg_ff;
   assign p2_neg = (mode_ff == MODE_SUB) ? ~bn_neg_ff : bn_neg_ff;
   always_comb begin
      add_same = (an_neg_ff == p2_neg);
      sum_w    = '0;
      if (add_same) begin
         sum_w   = {1'b0, p1_ff} + {1'b0, prod};
         sum_neg = an_neg_ff;
      end else if (p1_ff >= prod) begin
         sum_w   = {1'b0, p1_ff - prod};
         sum_neg = an_neg_ff;
      end else begin
         sum_w   = {1'b0, prod - p1_ff};
         sum_neg = p2_neg;
      end
      sum_m = sum_w[M-1:0];
      if (sum_m == 0) sum_neg = 1'b0;
   end

   assign dctl.start = (state_ff == S_G_START) || (state_ff == S_Q1_START) ||
      (state_ff == S_Q2_START) || (state_ff == S_L1_START) ||
      (state_ff == S_L3_START) || (state_ff == S_L4_START);
   always_comb begin
      dvd = ga_ff;
      dvs = gb_ff;
      case (state_ff)
         S_Q1_START: begin dvd = n_ff; dvs = s_ff; end
         S_Q2_START: begin dvd = d_ff; dvs = s_ff; end
         S_L1_START: begin dvd = ad_ff; dvs = s_ff; end
         S_L3_START: begin dvd = l_ff; dvs = ad_ff; end
         S_L4_START: begin dvd = l_ff; dvs = bd_ff; end
         default: ;
      endcase
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = (state_ff == S_OUT);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         case (state_ff)
            S_IDLE: if (req_valid) begin
               mode_ff   <= req_mode;
               an_neg_ff <= req_a_num[31] ^ req_a_den[31];
               bn_neg_ff <= req_b_num[31] ^ req_b_den[31];
               an_ff <= absf(req_a_num); ad_ff <= absf(req_a_den);
               bn_ff <= absf(req_b_num); bd_ff <= absf(req_b_den);
               n_ff  <= absf(req_a_num); d_ff <= absf(req_a_den);
               ga_ff <= absf(req_a_num); gb_ff <= absf(req_a_den);
               n_neg_ff <= req_a_num[31] ^ req_a_den[31];
               eq_ff <= 1'b0;
               rsp_res_num <= '0; rsp_res_den <= '0;
               phase_ff <= 2'd0;
               if (req_a_den == 0 || req_b_den == 0) begin
                  st_ff <= ST_ZERO_DEN;
                  state_ff <= S_OUT;
               end else begin
                  st_ff <= ST_OK;
                  state_ff <= S_G_START;
               end
            end
            // Euclid: ga, gb -> gcd in ga
            S_G_START: begin
               if (gb_ff == 0) begin
                  s_ff <= (ga_ff == 0) ? mag_type'(1) : ga_ff;
                  state_ff <= (phase_ff == 2'd3) ? S_L2 : S_Q1_START;
               end else state_ff <= S_G_WAIT;
            end
            S_G_WAIT: if (ddone) begin
               ga_ff <= gb_ff; gb_ff <= dr; state_ff <= S_G_START;
            end
            S_Q1_START: state_ff <= S_Q1_WAIT;
            S_Q1_WAIT: if (ddone) begin n_ff <= dq; state_ff <= S_Q2_START; end
            S_Q2_START: state_ff <= S_Q2_WAIT;
            S_Q2_WAIT: if (ddone) begin d_ff <= dq; state_ff <= S_RED_DONE; end
            S_RED_DONE: begin
               rn_neg_ff <= (n_ff == 0) ? 1'b0 : n_neg_ff;
               if (!fit((n_ff != 0) && n_neg_ff, n_ff, top) || !fit(1'b0, d_ff, top)) begin
                  st_ff <= ST_OVERFLOW; state_ff <= S_OUT;
               end else if (phase_ff == 2'd0) begin
                  an_ff <= n_ff; ad_ff <= d_ff;
                  an_neg_ff <= (n_ff != 0) && n_neg_ff;
                  n_ff <= bn_ff; d_ff <= bd_ff; ga_ff <= bn_ff; gb_ff <= bd_ff;
                  n_neg_ff <= bn_neg_ff;
                  phase_ff <= 2'd1; state_ff <= S_G_START;
               end else if (phase_ff == 2'd1) begin
                  bn_ff <= n_ff; bd_ff <= d_ff;
                  bn_neg_ff <= (n_ff != 0) && n_neg_ff;
                  state_ff <= S_OP;
               end else begin
                  state_ff <= S_CHECK;
               end
            end
            S_OP: begin
               case (mode_ff)
                  MODE_ADD, MODE_SUB: begin
                     ga_ff <= ad_ff; gb_ff <= bd_ff;
                     state_ff <= S_G_START;
                  end
                  MODE_MUL: begin
                     x_ff <= an_ff; y_ff <= bn_ff; state_ff <= S_MUL;
                  end
                  MODE_DIV: begin
                     if (bn_ff == 0) begin
                        st_ff <= ST_DIV_ZERO; state_ff <= S_OUT;
                     end else begin
                        x_ff <= an_ff; y_ff <= bd_ff; state_ff <= S_MUL;
                     end
                  end
                  MODE_CMP: begin
                     x_ff <= an_ff; y_ff <= bd_ff; state_ff <= S_MUL;
                  end
                  default: state_ff <= S_OUT;
               endcase
               n_neg_ff <= an_neg_ff ^ bn_neg_ff;
               phase_ff <= (mode_ff == MODE_ADD || mode_ff == MODE_SUB) ? 2'd3 : 2'd0;
            end
            // first product in S_MUL, second in S_L5 (reused name for mul 2)
            S_MUL: begin
               p1_ff <= prod;
               if (mode_ff == MODE_MUL) begin x_ff <= ad_ff; y_ff <= bd_ff; end
               else if (mode_ff == MODE_DIV) begin x_ff <= ad_ff; y_ff <= bn_ff; end
               else begin x_ff <= bn_ff; y_ff <= ad_ff; end
               state_ff <= S_L5;
            end
            // lcm: l = (ad / g) * bd
            S_L2: begin
               state_ff <= S_L1_START;
            end
            S_L1_START: state_ff <= S_L1_WAIT;
            S_L1_WAIT: if (ddone) begin x_ff <= dq; y_ff <= bd_ff; state_ff <= S_L3_START;
               phase_ff <= 2'd2; end
            S_L3_START: begin
               if (phase_ff == 2'd2) begin
                  l_ff <= prod; phase_ff <= 2'd0;
                  if (!fit(1'b0, prod, top)) begin
                     st_ff <= ST_OVERFLOW; state_ff <= S_OUT;
                  end
               end else state_ff <= S_L3_WAIT;
            end
            S_L3_WAIT: if (ddone) begin x_ff <= an_ff; y_ff <= dq; state_ff <= S_L4_START;
               phase_ff <= 2'd2; end
            S_L4_START: begin
               if (phase_ff == 2'd2) begin p1_ff <= prod; phase_ff <= 2'd0; end
               else state_ff <= S_L4_WAIT;
            end
            S_L4_WAIT: if (ddone) begin x_ff <= bn_ff; y_ff <= dq; state_ff <= S_L5; end
            S_L5: begin
               if (mode_ff == MODE_ADD || mode_ff == MODE_SUB) begin
                  if (!fit(an_neg_ff && p1_ff != 0, p1_ff, top) ||
                      !fit(p2_neg && prod != 0, prod, top) ||
                      !fit(sum_neg, sum_m, top)) begin
                     st_ff <= ST_OVERFLOW; state_ff <= S_OUT;
                  end else begin
                     n_ff <= sum_m; d_ff <= l_ff; n_neg_ff <= sum_neg;
                     ga_ff <= sum_m; gb_ff <= l_ff; phase_ff <= 2'd2;
                     state_ff <= S_G_START;
                  end
               end else begin
                  if (!fit(xp1_neg && p1_ff != 0, p1_ff, top) ||
                      !fit(xp2_neg && prod != 0, prod, top)) begin
                     st_ff <= ST_OVERFLOW; state_ff <= S_OUT;
                  end else if (mode_ff == MODE_CMP) begin
                     // reduced numerators carry the signs; zero is never negative
                     eq_ff <= (p1_ff == prod) && (an_neg_ff == bn_neg_ff);
                     state_ff <= S_OUT;
                  end else begin
                     n_ff <= p1_ff; d_ff <= prod;
                     ga_ff <= p1_ff; gb_ff <= prod; phase_ff <= 2'd2;
                     state_ff <= S_G_START;
                  end
               end
            end
            S_CHECK: begin
               if ((rn_neg_ff ? n_ff > 64'h8000_0000 : n_ff > 64'h7FFF_FFFF) ||
                   d_ff > 64'h7FFF_FFFF) begin
                  st_ff <= ST_OVERFLOW;
               end else begin
                  rsp_res_num <= rn_neg_ff ? 32'(~n_ff + 1'b1) : n_ff[31:0];
                  rsp_res_den <= d_ff[30:0];
               end
               state_ff <= S_OUT;
            end
            S_OUT: if (rsp_ready) state_ff <= S_IDLE;
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   // L3/L4 take an extra multiply pass flagged by phase 2 before dividing
   assign rsp_status   = st_ff;
   assign rsp_is_equal = (st_ff == ST_OK) && eq_ff;

   a_out_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status))
      else $error("result changed while stalled");
   a_busy: assert property (@(posedge clock) disable iff (reset)
      !(req_ready && rsp_valid)) else $error("ready while result pending");
   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != ST_OK |-> rsp_res_den == 0 && !rsp_is_equal)
      else $error("error result not zero");
endmodule
`default_nettype wire
